// File: hdl/fee_pkg.sv
// shared constants and helpers for the two-page flash eeprom emulator
`default_nettype none
package fee_pkg;

  // default geometry
  localparam int PAGE_BYTES_DEF = 1024;
  localparam int NUM_VARS_DEF   = 8;
  localparam int MAX_VAR_BYTES  = 8;

  // signed width of scan pointers, covers a page and the longest record jump
  localparam int IW = 18;

  localparam logic [31:0] ONES32  = 32'hFFFF_FFFF;
  localparam logic [31:0] MARK32  = 32'hEEEE_EEEE;
  localparam logic [15:0] NO_ADDR = 16'hFFFF;

  // operations
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // result status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_NO_VALID  = 3'd2;
  localparam logic [2:0] ST_PAGE_FULL = 3'd3;
  localparam logic [2:0] ST_SIZE_OVF  = 3'd4;

  // page states
  localparam logic [1:0] PG_ERASED  = 2'd0;
  localparam logic [1:0] PG_RECEIVE = 2'd1;
  localparam logic [1:0] PG_VALID   = 2'd2;
  localparam logic [1:0] PG_OTHER   = 2'd3;

  // decode a page status pair
  function automatic logic [1:0] page_kind(input logic [31:0] w0, input logic [31:0] w1);
    logic [1:0] k;
    if (w0 == ONES32 && w1 == ONES32) k = PG_ERASED;
    else if (w0 == ONES32 && w1 == MARK32) k = PG_RECEIVE;
    else if (w0 == 32'h0 && w1 == MARK32) k = PG_VALID;
    else k = PG_OTHER;
    return k;
  endfunction

  // keep the low n bytes of a 64-bit word
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (n > 4'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: hdl/fee_flash.sv
// single-port flash word array with registered read data
`default_nettype none
module fee_flash #(
  parameter int AW = 9
) (
  input  wire logic          clk,
  input  wire logic          mem_we,
  input  wire logic [AW-1:0] mem_addr,
  input  wire logic [31:0]   mem_wdata,
  output logic      [31:0]   mem_rdata
);

  logic [31:0] mem_r [2**AW];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem_r[mem_addr];
  end

  assign mem_rdata = rdata_r;

endmodule
`default_nettype wire

// File: hdl/fee_ctrl.sv
// operation sequencer: page state decode, record scan, append, copy, erase
`default_nettype none
module fee_ctrl #(
  parameter int PAGE_BYTES = fee_pkg::PAGE_BYTES_DEF,
  parameter int NUM_VARS   = fee_pkg::NUM_VARS_DEF,
  localparam int PW  = PAGE_BYTES / 4,
  localparam int PWB = $clog2(PW),
  localparam int AW  = PWB + 1,
  localparam int VIW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_operation,
  input  wire logic [15:0]            in_var_address,
  input  wire logic [63:0]            in_write_data,
  input  wire logic [3:0]             in_byte_count,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  out_status,
  output logic [63:0]                 out_read_data,
  output logic [3:0]                  out_read_length,
  input  wire logic [16*NUM_VARS-1:0] slots,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_addr,
  output logic [31:0]                 mem_wdata,
  input  wire logic [31:0]            mem_rdata
);

  localparam int IW = fee_pkg::IW;

  localparam logic [5:0] S_CLR      = 6'd0;
  localparam logic [5:0] S_IDLE     = 6'd1;
  localparam logic [5:0] S_FIN      = 6'd2;
  localparam logic [5:0] S_OK_FIN   = 6'd3;
  localparam logic [5:0] S_RD_DONE  = 6'd4;
  localparam logic [5:0] S_KI_I     = 6'd5;
  localparam logic [5:0] S_KI_C     = 6'd6;
  localparam logic [5:0] S_RDV      = 6'd7;
  localparam logic [5:0] S_RDV_K    = 6'd8;
  localparam logic [5:0] S_RDS_I    = 6'd9;
  localparam logic [5:0] S_RDS_C    = 6'd10;
  localparam logic [5:0] S_RDD0_I   = 6'd11;
  localparam logic [5:0] S_RDD0_C   = 6'd12;
  localparam logic [5:0] S_RDD1_I   = 6'd13;
  localparam logic [5:0] S_RDD1_C   = 6'd14;
  localparam logic [5:0] S_AP       = 6'd15;
  localparam logic [5:0] S_AP_K     = 6'd16;
  localparam logic [5:0] S_APS_I    = 6'd17;
  localparam logic [5:0] S_APS_C    = 6'd18;
  localparam logic [5:0] S_APW      = 6'd19;
  localparam logic [5:0] S_ER       = 6'd20;
  localparam logic [5:0] S_MV_I     = 6'd21;
  localparam logic [5:0] S_MV_C     = 6'd22;
  localparam logic [5:0] S_MV_W     = 6'd23;
  localparam logic [5:0] S_CP_N     = 6'd24;
  localparam logic [5:0] S_CP_R     = 6'd25;
  localparam logic [5:0] S_CP_A     = 6'd26;
  localparam logic [5:0] S_WR_AP1   = 6'd27;
  localparam logic [5:0] S_PT_A     = 6'd28;
  localparam logic [5:0] S_PT_C     = 6'd29;
  localparam logic [5:0] S_PT_E     = 6'd30;
  localparam logic [5:0] S_INIT_DEC = 6'd31;
  localparam logic [5:0] S_FMT1     = 6'd32;
  localparam logic [5:0] S_FMT2     = 6'd33;
  localparam logic [5:0] S_I_MV     = 6'd34;
  localparam logic [5:0] S_I_CPD    = 6'd35;
  localparam logic [5:0] S_I_ER     = 6'd36;
  localparam logic [5:0] S_FF_I     = 6'd37;
  localparam logic [5:0] S_FF_C     = 6'd38;

  localparam logic [PWB-1:0] W_ZERO = '0;
  localparam logic [PWB-1:0] W_ONE  = PWB'(1);
  localparam logic [PWB-1:0] W_LAST = PWB'(PW - 1);

  // control registers
  logic [5:0]    state_r, state_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic [5:0]  ret_k_r, ret_k_nxt, ret_rd_r, ret_rd_nxt, ret_ap_r, ret_ap_nxt;
  logic [5:0]  ret_cp_r, ret_cp_nxt, ret_er_r, ret_er_nxt, ret_mv_r, ret_mv_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [1:0]  k0_r, k0_nxt, k1_r, k1_nxt, kc_r, kc_nxt;
  logic [31:0] w0_r, w0_nxt, d0_r, d0_nxt;
  logic signed [IW-1:0] i_r, i_nxt, abs_r, abs_nxt;
  logic        page_r, page_nxt, ap_page_r, ap_page_nxt, mvp_r, mvp_nxt, erp_r, erp_nxt;
  logic [15:0] rd_target_r, rd_target_nxt, skip_r, skip_nxt, ff_a_r, ff_a_nxt;
  logic [3:0]  rd_req_r, rd_req_nxt, rd_n_r, rd_n_nxt;
  logic [2:0]  rd_st_r, rd_st_nxt, ap_st_r, ap_st_nxt, cp_st_r, cp_st_nxt;
  logic [2:0]  res_st_r, res_st_nxt;
  logic [63:0] rd_data_r, rd_data_nxt;
  logic [15:0] ap_addr_r, ap_addr_nxt;
  logic [63:0] ap_data_r, ap_data_nxt;
  logic [3:0]  ap_size_r, ap_size_nxt;
  logic [1:0]  ak_r, ak_nxt;
  logic [VIW:0] vi_r, vi_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [63:0] odata_r, odata_nxt;
  logic [3:0]  olen_r, olen_nxt;

  // shared scan arithmetic on the word just read
  logic [15:0] w_a, w_len, cur_slot;
  logic        w_rec;
  logic signed [IW-1:0] w_wl, i_jump, free_w, need_w, page_base;
  logic [3:0]  n_pick;
  logic [1:0]  ap_nw;
  logic [63:0] ap_masked;

  always_comb begin
    w_a       = mem_rdata[31:16];
    w_len     = mem_rdata[15:0];
    w_wl      = (w_len != 16'hFFFF) ? IW'((32'(w_len) + 32'd3) >> 2) : '0;
    w_rec     = (w_a != fee_pkg::NO_ADDR) && (w_len != 16'hFFFF);
    i_jump    = i_r - w_wl - IW'(1);
    free_w    = IW'(PW - 1) - i_r;
    need_w    = IW'(ap_size_r) + IW'(4);
    page_base = IW'({page_r, W_ZERO});
    n_pick    = ({12'h0, rd_req_r} > w_len) ? w_len[3:0] : rd_req_r;
    if (n_pick > 4'd8) n_pick = 4'd8;
    ap_nw     = 2'((5'(ap_size_r) + 5'd3) >> 2);
    ap_masked = ap_data_r & fee_pkg::byte_mask(ap_size_r);
    cur_slot  = slots[16*vi_r[VIW-1:0] +: 16];
  end

  always_comb begin
    state_nxt = state_r; j_nxt = j_r;
    out_valid_nxt = out_valid_r && out_stall;
    ret_k_nxt = ret_k_r; ret_rd_nxt = ret_rd_r; ret_ap_nxt = ret_ap_r;
    ret_cp_nxt = ret_cp_r; ret_er_nxt = ret_er_r; ret_mv_nxt = ret_mv_r;
    op_nxt = op_r; k0_nxt = k0_r; k1_nxt = k1_r; kc_nxt = kc_r;
    w0_nxt = w0_r; d0_nxt = d0_r; i_nxt = i_r; abs_nxt = abs_r;
    page_nxt = page_r; ap_page_nxt = ap_page_r; mvp_nxt = mvp_r; erp_nxt = erp_r;
    rd_target_nxt = rd_target_r; skip_nxt = skip_r; ff_a_nxt = ff_a_r;
    rd_req_nxt = rd_req_r; rd_n_nxt = rd_n_r; rd_st_nxt = rd_st_r;
    ap_st_nxt = ap_st_r; cp_st_nxt = cp_st_r; res_st_nxt = res_st_r;
    rd_data_nxt = rd_data_r; ap_addr_nxt = ap_addr_r; ap_data_nxt = ap_data_r;
    ap_size_nxt = ap_size_r; ak_nxt = ak_r; vi_nxt = vi_r;
    ost_nxt = ost_r; odata_nxt = odata_r; olen_nxt = olen_r;
    mem_we = 1'b0; mem_addr = '0; mem_wdata = '0;

    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1; mem_addr = j_r; mem_wdata = fee_pkg::ONES32;
        j_nxt = j_r + AW'(1);
        if (j_r == {AW{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          kc_nxt = '0;
          unique case (in_operation)
            fee_pkg::OP_INIT: begin
              ret_k_nxt = S_INIT_DEC; state_nxt = S_KI_I;
            end
            fee_pkg::OP_READ: begin
              rd_target_nxt = in_var_address; rd_req_nxt = in_byte_count;
              ret_rd_nxt = S_RD_DONE; state_nxt = S_RDV;
            end
            fee_pkg::OP_WRITE: begin
              ap_addr_nxt = in_var_address; ap_data_nxt = in_write_data;
              ap_size_nxt = in_byte_count; ret_ap_nxt = S_WR_AP1;
              if (in_byte_count > 4'(fee_pkg::MAX_VAR_BYTES)) begin
                res_st_nxt = fee_pkg::ST_SIZE_OVF; state_nxt = S_FIN;
              end else if (in_byte_count == 4'd0) begin
                res_st_nxt = fee_pkg::ST_OK; state_nxt = S_FIN;
              end else begin
                state_nxt = S_AP;
              end
            end
            default: begin
              res_st_nxt = fee_pkg::ST_OK; state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          ost_nxt   = res_st_r;
          odata_nxt = (op_r == fee_pkg::OP_READ) ? rd_data_r : 64'h0;
          olen_nxt  = (op_r == fee_pkg::OP_READ) ? rd_n_r : 4'd0;
          state_nxt = S_IDLE;
        end
      end
      S_OK_FIN: begin
        res_st_nxt = fee_pkg::ST_OK; state_nxt = S_FIN;
      end
      S_RD_DONE: begin
        res_st_nxt = rd_st_r; state_nxt = S_FIN;
      end
      S_KI_I: begin
        mem_addr = {kc_r[1], W_ZERO[PWB-1:1], kc_r[0]};
        state_nxt = S_KI_C;
      end
      S_KI_C: begin
        if (!kc_r[0]) w0_nxt = mem_rdata;
        else if (kc_r[1]) k1_nxt = fee_pkg::page_kind(w0_r, mem_rdata);
        else k0_nxt = fee_pkg::page_kind(w0_r, mem_rdata);
        kc_nxt = kc_r + 2'd1;
        state_nxt = (kc_r == 2'd3) ? ret_k_r : S_KI_I;
      end
      S_RDV: begin
        kc_nxt = '0; ret_k_nxt = S_RDV_K; state_nxt = S_KI_I;
      end
      S_RDV_K: begin
        rd_data_nxt = '0; rd_n_nxt = '0;
        i_nxt = IW'(PW - 1);
        page_nxt = (k0_r != fee_pkg::PG_VALID);
        if (k0_r != fee_pkg::PG_VALID && k1_r != fee_pkg::PG_VALID) begin
          rd_st_nxt = fee_pkg::ST_NO_VALID; state_nxt = ret_rd_r;
        end else if (rd_target_r == fee_pkg::NO_ADDR) begin
          rd_st_nxt = fee_pkg::ST_NOT_FOUND; state_nxt = ret_rd_r;
        end else begin
          state_nxt = S_RDS_I;
        end
      end
      S_RDS_I: begin
        mem_addr = {page_r, i_r[PWB-1:0]};
        if (i_r > 2) state_nxt = S_RDS_C;
        else begin
          rd_st_nxt = fee_pkg::ST_NOT_FOUND; state_nxt = ret_rd_r;
        end
      end
      S_RDS_C: begin
        if (w_a == rd_target_r) begin
          rd_n_nxt = n_pick;
          abs_nxt = page_base + i_r - w_wl;
          state_nxt = S_RDD0_I;
        end else begin
          i_nxt = w_rec ? i_jump : (i_r - IW'(1));
          state_nxt = S_RDS_I;
        end
      end
      S_RDD0_I: begin
        mem_addr = abs_r[AW-1:0]; state_nxt = S_RDD0_C;
      end
      S_RDD0_C: begin
        d0_nxt = (abs_r < 0 || abs_r >= 2*PW) ? fee_pkg::ONES32 : mem_rdata;
        abs_nxt = abs_r + IW'(1);
        state_nxt = S_RDD1_I;
      end
      S_RDD1_I: begin
        mem_addr = abs_r[AW-1:0]; state_nxt = S_RDD1_C;
      end
      S_RDD1_C: begin
        rd_data_nxt = {((abs_r < 0 || abs_r >= 2*PW) ? fee_pkg::ONES32 : mem_rdata), d0_r}
                      & fee_pkg::byte_mask(rd_n_r);
        rd_st_nxt = fee_pkg::ST_OK;
        state_nxt = ret_rd_r;
      end
      S_AP: begin
        kc_nxt = '0; ret_k_nxt = S_AP_K; state_nxt = S_KI_I;
      end
      S_AP_K: begin
        i_nxt = IW'(PW - 1);
        if (ap_size_r == 4'd0) begin
          ap_st_nxt = fee_pkg::ST_OK; state_nxt = ret_ap_r;
        end else if (k1_r == fee_pkg::PG_VALID) begin
          ap_page_nxt = (k0_r != fee_pkg::PG_RECEIVE); state_nxt = S_APS_I;
        end else if (k0_r == fee_pkg::PG_VALID) begin
          ap_page_nxt = (k1_r == fee_pkg::PG_RECEIVE); state_nxt = S_APS_I;
        end else begin
          ap_st_nxt = fee_pkg::ST_NO_VALID; state_nxt = ret_ap_r;
        end
      end
      S_APS_I: begin
        mem_addr = {ap_page_r, i_r[PWB-1:0]};
        if (i_r >= 1) state_nxt = S_APS_C;
        else begin
          ap_st_nxt = fee_pkg::ST_PAGE_FULL; state_nxt = ret_ap_r;
        end
      end
      S_APS_C: begin
        if (mem_rdata != fee_pkg::ONES32) begin
          if ((free_w <<< 2) < need_w) begin
            ap_st_nxt = fee_pkg::ST_PAGE_FULL; state_nxt = ret_ap_r;
          end else begin
            i_nxt = i_r + IW'(1); ak_nxt = '0; state_nxt = S_APW;
          end
        end else begin
          i_nxt = i_r - IW'(1); state_nxt = S_APS_I;
        end
      end
      S_APW: begin
        mem_we = 1'b1;
        mem_addr = {ap_page_r, i_r[PWB-1:0]};
        if (ak_r < ap_nw) begin
          mem_wdata = ak_r[0] ? ap_masked[63:32] : ap_masked[31:0];
          i_nxt = i_r + IW'(1); ak_nxt = ak_r + 2'd1;
        end else begin
          mem_wdata = {ap_addr_r, 12'h0, ap_size_r};
          ap_st_nxt = fee_pkg::ST_OK; state_nxt = ret_ap_r;
        end
      end
      S_ER: begin
        mem_we = 1'b1; mem_addr = {erp_r, j_r[PWB-1:0]}; mem_wdata = fee_pkg::ONES32;
        j_nxt = j_r + AW'(1);
        if (j_r[PWB-1:0] == W_LAST) state_nxt = ret_er_r;
      end
      S_MV_I: begin
        mem_addr = {mvp_r, W_ONE}; state_nxt = S_MV_C;
      end
      S_MV_C: begin
        mem_addr = {mvp_r, W_ONE};
        mem_we = (mem_rdata == fee_pkg::ONES32);
        mem_wdata = fee_pkg::MARK32;
        state_nxt = S_MV_W;
      end
      S_MV_W: begin
        mem_we = 1'b1; mem_addr = {mvp_r, W_ZERO}; mem_wdata = 32'h0;
        state_nxt = ret_mv_r;
      end
      S_CP_N: begin
        if (vi_r == (VIW+1)'(NUM_VARS)) begin
          cp_st_nxt = fee_pkg::ST_OK; state_nxt = ret_cp_r;
        end else if (cur_slot == skip_r || cur_slot == fee_pkg::NO_ADDR) begin
          vi_nxt = vi_r + (VIW+1)'(1);
        end else begin
          rd_target_nxt = cur_slot; rd_req_nxt = 4'(fee_pkg::MAX_VAR_BYTES);
          ret_rd_nxt = S_CP_R; state_nxt = S_RDV;
        end
      end
      S_CP_R: begin
        if (rd_st_r != fee_pkg::ST_OK) begin
          vi_nxt = vi_r + (VIW+1)'(1); state_nxt = S_CP_N;
        end else begin
          ap_addr_nxt = rd_target_r; ap_data_nxt = rd_data_r; ap_size_nxt = rd_n_r;
          ret_ap_nxt = S_CP_A; state_nxt = S_AP;
        end
      end
      S_CP_A: begin
        if (ap_st_r != fee_pkg::ST_OK) begin
          cp_st_nxt = ap_st_r; state_nxt = ret_cp_r;
        end else begin
          vi_nxt = vi_r + (VIW+1)'(1); state_nxt = S_CP_N;
        end
      end
      S_WR_AP1: begin
        if (ap_st_r != fee_pkg::ST_PAGE_FULL) begin
          res_st_nxt = ap_st_r; state_nxt = S_FIN;
        end else if (k0_r != fee_pkg::PG_VALID && k1_r != fee_pkg::PG_VALID) begin
          res_st_nxt = fee_pkg::ST_NO_VALID; state_nxt = S_FIN;
        end else begin
          // old page is the readable one, the other starts receiving
          erp_nxt = (k0_r != fee_pkg::PG_VALID);
          mem_we = 1'b1;
          mem_addr = {(k0_r == fee_pkg::PG_VALID), W_ONE};
          mem_wdata = fee_pkg::MARK32;
          ret_ap_nxt = S_PT_A; state_nxt = S_AP;
        end
      end
      S_PT_A: begin
        if (ap_st_r != fee_pkg::ST_OK) begin
          res_st_nxt = ap_st_r; state_nxt = S_FIN;
        end else begin
          skip_nxt = ap_addr_r; vi_nxt = '0; ret_cp_nxt = S_PT_C; state_nxt = S_CP_N;
        end
      end
      S_PT_C: begin
        if (cp_st_r != fee_pkg::ST_OK) begin
          res_st_nxt = cp_st_r; state_nxt = S_FIN;
        end else begin
          j_nxt = '0; ret_er_nxt = S_PT_E; state_nxt = S_ER;
        end
      end
      S_PT_E: begin
        mvp_nxt = !erp_r; ret_mv_nxt = S_OK_FIN; state_nxt = S_MV_I;
      end
      S_INIT_DEC: begin
        j_nxt = '0;
        i_nxt = IW'(PW - 1);
        ff_a_nxt = fee_pkg::NO_ADDR;
        ret_er_nxt = S_OK_FIN;
        // default repair is a full format
        erp_nxt = 1'b0; ret_er_nxt = S_FMT1; state_nxt = S_ER;
        priority if (k0_r == fee_pkg::PG_ERASED && k1_r == fee_pkg::PG_VALID) begin
          ret_er_nxt = S_OK_FIN;
        end else if (k0_r == fee_pkg::PG_ERASED && k1_r == fee_pkg::PG_RECEIVE) begin
          mvp_nxt = 1'b1; ret_er_nxt = S_I_MV;
        end else if (k0_r == fee_pkg::PG_RECEIVE && k1_r == fee_pkg::PG_VALID) begin
          page_nxt = 1'b0; mvp_nxt = 1'b0; erp_nxt = 1'b1; state_nxt = S_FF_I;
        end else if (k0_r == fee_pkg::PG_RECEIVE && k1_r == fee_pkg::PG_ERASED) begin
          erp_nxt = 1'b1; mvp_nxt = 1'b0; ret_er_nxt = S_I_MV;
        end else if (k0_r == fee_pkg::PG_VALID && k1_r == fee_pkg::PG_ERASED) begin
          erp_nxt = 1'b1; ret_er_nxt = S_OK_FIN;
        end else if (k0_r == fee_pkg::PG_VALID &&
                     (k1_r == fee_pkg::PG_RECEIVE || k1_r == fee_pkg::PG_OTHER)) begin
          page_nxt = 1'b1; mvp_nxt = 1'b1; erp_nxt = 1'b0; state_nxt = S_FF_I;
        end else begin
          ret_er_nxt = S_FMT1;
        end
      end
      S_FMT1: begin
        mvp_nxt = 1'b0; ret_mv_nxt = S_FMT2; state_nxt = S_MV_I;
      end
      S_FMT2: begin
        erp_nxt = 1'b1; j_nxt = '0; ret_er_nxt = S_OK_FIN; state_nxt = S_ER;
      end
      S_I_MV: begin
        ret_mv_nxt = S_OK_FIN; state_nxt = S_MV_I;
      end
      S_I_CPD: begin
        if (cp_st_r != fee_pkg::ST_OK) begin
          res_st_nxt = cp_st_r; state_nxt = S_FIN;
        end else begin
          ret_mv_nxt = S_I_ER; state_nxt = S_MV_I;
        end
      end
      S_I_ER: begin
        j_nxt = '0; ret_er_nxt = S_OK_FIN; state_nxt = S_ER;
      end
      S_FF_I: begin
        mem_addr = {page_r, i_r[PWB-1:0]};
        if (i_r > 2) state_nxt = S_FF_C;
        else begin
          skip_nxt = ff_a_r; vi_nxt = '0; ret_cp_nxt = S_I_CPD; state_nxt = S_CP_N;
        end
      end
      S_FF_C: begin
        ff_a_nxt = w_a;
        i_nxt = w_rec ? i_jump : (i_r - IW'(1));
        state_nxt = S_FF_I;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      j_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_k_r <= ret_k_nxt; ret_rd_r <= ret_rd_nxt; ret_ap_r <= ret_ap_nxt;
    ret_cp_r <= ret_cp_nxt; ret_er_r <= ret_er_nxt; ret_mv_r <= ret_mv_nxt;
    op_r <= op_nxt; k0_r <= k0_nxt; k1_r <= k1_nxt; kc_r <= kc_nxt;
    w0_r <= w0_nxt; d0_r <= d0_nxt; i_r <= i_nxt; abs_r <= abs_nxt;
    page_r <= page_nxt; ap_page_r <= ap_page_nxt; mvp_r <= mvp_nxt; erp_r <= erp_nxt;
    rd_target_r <= rd_target_nxt; skip_r <= skip_nxt; ff_a_r <= ff_a_nxt;
    rd_req_r <= rd_req_nxt; rd_n_r <= rd_n_nxt; rd_st_r <= rd_st_nxt;
    ap_st_r <= ap_st_nxt; cp_st_r <= cp_st_nxt; res_st_r <= res_st_nxt;
    rd_data_r <= rd_data_nxt; ap_addr_r <= ap_addr_nxt; ap_data_r <= ap_data_nxt;
    ap_size_r <= ap_size_nxt; ak_r <= ak_nxt; vi_r <= vi_nxt;
    ost_r <= ost_nxt; odata_r <= odata_nxt; olen_r <= olen_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = ost_r;
  assign out_read_data   = odata_r;
  assign out_read_length = olen_r;

`ifndef ASSERT_OFF
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && j_r == {AW{1'b1}}) |=> state_r == S_IDLE)
    else $error("clearing pass did not end in idle");
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we)
    else $error("flash written while idle");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_read_length <= 4'd8)
    else $error("read length above eight");
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != fee_pkg::ST_OK) |-> (out_read_length == 4'd0 &&
    out_read_data == 64'h0))
    else $error("failed request returned data");
`endif

endmodule
`default_nettype wire

// File: hdl/flash_eeprom_emulator_unit.sv
// top level: variable slot registers, sequencer and flash array
`default_nettype none
// Two-page flash EEPROM emulation over an internal array of 2*PAGE_BYTES/4 words.
// One request is taken at a time; in_stall stays high until its result is loaded
// into the output register. The sequencer touches the single-port flash array
// once per cycle, and each scanned word takes an issue state and a check state:
// a read steps over words from the top of the valid page; a write searches
// down from the top for free space; a page transfer or an init that copies
// variables repeats a read and an append for each used one of the NUM_VARS
// slots and then erases a page. After reset a clearing pass sets every word to
// ones, and no request is taken meanwhile. Slot registers are written through
// the cfg port; the user must write them only between requests, while none is
// in flight, and the block itself does not enforce this. Index i selects
// var_slot_i, 0xffff marking an unused slot.
module flash_eeprom_emulator_unit #(
  parameter int PAGE_BYTES = fee_pkg::PAGE_BYTES_DEF,
  parameter int NUM_VARS   = fee_pkg::NUM_VARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_var_address,
  input  wire logic [63:0] in_write_data,
  input  wire logic [3:0]  in_byte_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [63:0]      out_read_data,
  output logic [3:0]       out_read_length,
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int PW  = PAGE_BYTES / 4;
  localparam int AW  = $clog2(PW) + 1;

  // variable slots, only the first NUM_VARS are kept
  logic [16*NUM_VARS-1:0] slots_r;

  for (genvar v = 0; v < NUM_VARS; v++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        slots_r[16*v +: 16] <= fee_pkg::NO_ADDR;
      end else if (cfg_write_en && cfg_index == 3'(v)) begin
        slots_r[16*v +: 16] <= cfg_data;
      end
    end
  end

  // flash array port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  fee_ctrl #(
    .PAGE_BYTES(PAGE_BYTES),
    .NUM_VARS  (NUM_VARS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_var_address (in_var_address),
    .in_write_data  (in_write_data),
    .in_byte_count  (in_byte_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_read_length(out_read_length),
    .slots          (slots_r),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  fee_flash #(
    .AW(AW)
  ) u_flash (
    .clk      (clk),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata)
  );

endmodule
`default_nettype wire
